>>> rtl/ptsp_pkg.sv
package ptsp_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W = 32;
    localparam int FRAC_W = 17;
    localparam int CFG_IDX_W = 3;
    localparam logic [16:0] FRACTION_ONE = 17'd65536;
    localparam int NEAR_DEGREES = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_POS = 3'd0,
        REG_END_POS   = 3'd1,
        REG_START_SPD = 3'd2,
        REG_MAX_SPD   = 3'd3,
        REG_FINAL_SPD = 3'd4,
        REG_ACCEL_FR  = 3'd5,
        REG_DECEL_FR  = 3'd6
    } t_reg_idx;

    // Start request toward a serial arithmetic unit; done comes back on a separate port.
    typedef struct packed {
        logic start;
    } t_unit_req;
endpackage

>>> rtl/ptsp_mul.sv
// Shift-add multiplier: one multiplier bit per cycle, unsigned.
module ptsp_mul #(
    parameter int A_W = 64,
    parameter int B_W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptsp_pkg::t_unit_req  i_req,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic                 o_done,
    output logic [A_W+B_W-1:0]   o_p
);
    import ptsp_pkg::*;
    localparam int CW = $clog2(B_W + 1);
    logic [A_W+B_W-1:0] r_acc;
    logic [A_W+B_W-1:0] r_a;
    logic [B_W-1:0]     r_b;
    logic [CW-1:0]      r_cnt;
    logic               r_busy, r_done;

    // Step through multiplier bits from the LSB.
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_acc  <= '0;
            r_a    <= {{B_W{1'b0}}, i_a};
            r_b    <= i_b;
            r_cnt  <= CW'(B_W);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) r_acc <= r_acc + r_a;
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end
    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

>>> rtl/ptsp_div.sv
// Restoring divider: one quotient bit per cycle, quotient truncated to N_W bits.
module ptsp_div #(
    parameter int N_W = 64,
    parameter int D_W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptsp_pkg::t_unit_req  i_req,
    input  logic [N_W-1:0]       i_num,
    input  logic [D_W-1:0]       i_den,
    output logic                 o_done,
    output logic [N_W-1:0]       o_q
);
    import ptsp_pkg::*;
    localparam int CW = $clog2(N_W + 1);
    logic [N_W-1:0] r_n, r_q;
    logic [D_W:0]   r_rem;
    logic [D_W-1:0] r_d;
    logic [CW-1:0]  r_cnt;
    logic           r_busy, r_done;
    logic [D_W:0]   w_sh;

    assign w_sh = {r_rem[D_W-1:0], r_n[N_W-1]};

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_n    <= i_num;
            r_d    <= i_den;
            r_rem  <= '0;
            r_q    <= '0;
            r_cnt  <= CW'(N_W);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_n <= r_n << 1;
            if (w_sh >= {1'b0, r_d}) begin
                r_rem <= w_sh - {1'b0, r_d};
                r_q   <= {r_q[N_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[N_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end
    assign o_done = r_done;
    assign o_q    = r_q;
endmodule

>>> rtl/ptsp_sqrt.sv
// Digit-by-digit integer square root: one result bit per cycle.
module ptsp_sqrt #(
    parameter int X_W = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptsp_pkg::t_unit_req  i_req,
    input  logic [X_W-1:0]       i_x,
    output logic                 o_done,
    output logic [X_W/2-1:0]     o_root
);
    import ptsp_pkg::*;
    localparam int R_W = X_W / 2;
    localparam int CW = $clog2(R_W + 1);
    logic [X_W-1:0] r_x;
    logic [R_W+1:0] r_rem;
    logic [R_W-1:0] r_root;
    logic [CW-1:0]  r_cnt;
    logic           r_busy, r_done;
    logic [R_W+1:0] w_rem, w_trial;

    assign w_rem   = {r_rem[R_W-1:0], r_x[X_W-1:X_W-2]};
    assign w_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CW'(R_W);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_x <= r_x << 2;
            if (w_rem >= w_trial) begin
                r_rem  <= w_rem - w_trial;
                r_root <= {r_root[R_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem;
                r_root <= {r_root[R_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end
    assign o_done = r_done;
    assign o_root = r_root;
endmodule

>>> rtl/position_trapezoid_speed_planner.sv
// Position-based trapezoidal speed planner. One measured angle is taken per beat and one
// target speed (Q16.16 rpm, saturated) comes back with the reached and config_invalid
// flags. Items are worked one at a time by a sequencer over a shared bit-serial
// multiplier, divider and square-root unit, and the input stalls while the sequencer is
// busy. For a beat in a ramp phase the sequencer forms two squares of 32-bit speed
// magnitudes, a 64-bit divide, a scale and a root of a 64-bit value, each with a start
// and done handshake; a beat on the first point of the deceleration ramp skips the
// divide and scale. Cruise, outside and zero-length phase beats still form the phase
// lengths serially on every beat; a bad configuration skips the arithmetic units. The
// next angle is accepted on the edge after the result is written. The result is held in
// an output register, so a new angle is accepted while it waits; that next beat then
// holds its own result until the output register is free.
module position_trapezoid_speed_planner #(
    parameter int FRAC_BITS = ptsp_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ptsp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ptsp_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ptsp_pkg::WORD_W-1:0]  i_measured_angle,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ptsp_pkg::WORD_W-1:0]  o_target_speed,
    output logic                                o_reached,
    output logic                                o_config_invalid
);
    import ptsp_pkg::*;

    localparam logic [33:0] NEAR = 34'(NEAR_DEGREES) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SAC, S_SDE, S_CLASS, S_SQ_A, S_SQ_B, S_DIV, S_SCALE,
        S_ROOT, S_ZMUL, S_EMIT
    } t_state;

    // Configuration registers.
    logic signed [31:0] r_sp, r_ep, r_vs, r_vm, r_vf;
    logic [16:0]        r_af, r_df;
    logic               r_reached;

    t_state             r_state;
    logic signed [32:0] r_ang;
    logic [32:0]        r_ssu, r_sac, r_sde, r_num, r_den;
    logic [63:0]        r_v2a, r_v2b;
    logic               r_fwd;
    logic signed [31:0] r_spd;
    logic               r_bad;
    logic               r_ov;
    logic signed [31:0] r_out_spd;
    logic               r_out_rch, r_out_bad;

    // Shared unit operands and controls.
    t_unit_req          r_mreq, r_dreq, r_sreq;
    logic [63:0]        r_ma, r_sx;
    logic [31:0]        r_mb;
    logic [63:0]        r_dn;
    logic [32:0]        r_dd;
    logic               w_mdone, w_ddone, w_sdone;
    logic [95:0]        w_mp;
    logic [63:0]        w_dq;
    logic [31:0]        w_root;

    ptsp_mul #(.A_W(64), .B_W(32)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_mreq), .i_a(r_ma), .i_b(r_mb),
        .o_done(w_mdone), .o_p(w_mp));
    ptsp_div #(.N_W(64), .D_W(33)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_dreq), .i_num(r_dn), .i_den(r_dd),
        .o_done(w_ddone), .o_q(w_dq));
    ptsp_sqrt #(.X_W(64)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_sreq), .i_x(r_sx),
        .o_done(w_sdone), .o_root(w_root));

    // Combinational helpers.
    logic signed [32:0] w_sp, w_ep, w_dse, w_s, w_dend;
    logic [32:0]        w_sabs, w_dabs;
    logic [31:0]        w_mvs, w_mvm, w_mvf;
    logic               w_cfg_bad;
    logic signed [63:0] w_zp;
    logic [63:0]        w_zm;
    logic signed [63:0] w_zq;
    logic signed [31:0] w_zsat;
    logic [32:0]        w_cruise_end;

    assign w_sp   = 33'(r_sp);
    assign w_ep   = 33'(r_ep);
    assign w_dse  = w_ep - w_sp;
    assign w_s    = r_ang - w_sp;
    assign w_sabs = w_s[32] ? 33'(-w_s) : 33'(w_s);
    assign w_dend = r_ang - w_ep;
    assign w_dabs = w_dend[32] ? 33'(-w_dend) : 33'(w_dend);
    assign w_mvs  = r_vs[31] ? 32'(-r_vs) : 32'(r_vs);
    assign w_mvm  = r_vm[31] ? 32'(-r_vm) : 32'(r_vm);
    assign w_mvf  = r_vf[31] ? 32'(-r_vf) : 32'(r_vf);
    assign w_cfg_bad = (r_af > FRACTION_ONE) || (r_df > FRACTION_ONE) || (r_vm < r_vs);
    assign w_cruise_end = r_ssu - r_sde;

    // Signed zero-length product from the magnitude product, floor shift, saturate.
    assign w_zm = w_mp[63:0];
    assign w_zp = (r_vs[31] ^ r_vm[31]) ? -$signed(w_zm) : $signed(w_zm);
    assign w_zq = w_zp >>> FRAC_BITS;
    assign w_zsat = (w_zq > 64'sd2147483647) ? 32'sh7fffffff :
                    (w_zq < -64'sd2147483648) ? 32'sh80000000 : 32'(w_zq);

    // Final sign handling for the normal path.
    function automatic logic signed [31:0] f_dir(input logic signed [31:0] v,
                                                 input logic fwd);
        if (fwd) return v;
        if (v == 32'sh80000000) return 32'sh7fffffff;
        return -v;
    endfunction

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        r_mreq.start <= 1'b0;
        r_dreq.start <= 1'b0;
        r_sreq.start <= 1'b0;
        if (!i_rst_n) begin
            r_sp <= '0; r_ep <= '0; r_vs <= '0; r_vm <= '0; r_vf <= '0;
            r_af <= '0; r_df <= '0;
            r_reached <= 1'b0;
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_mreq.start <= 1'b0;
            r_dreq.start <= 1'b0;
            r_sreq.start <= 1'b0;
        end else begin
            if (o_valid && !i_stall && (r_state != S_EMIT)) o_valid <= 1'b0;
            // Register writes; only a known register clears the arrival flag.
            if (i_cfg_we) begin
                if (i_cfg_index <= REG_DECEL_FR) r_reached <= 1'b0;
                unique case (i_cfg_index)
                    REG_START_POS: r_sp <= i_cfg_data;
                    REG_END_POS:   r_ep <= i_cfg_data;
                    REG_START_SPD: r_vs <= i_cfg_data;
                    REG_MAX_SPD:   r_vm <= i_cfg_data;
                    REG_FINAL_SPD: r_vf <= i_cfg_data;
                    REG_ACCEL_FR:  r_af <= i_cfg_data[16:0];
                    REG_DECEL_FR:  r_df <= i_cfg_data[16:0];
                    default:       ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_ang <= 33'(i_measured_angle);
                        r_fwd <= (w_dse > 0);
                        r_ssu <= w_dse[32] ? 33'(-w_dse) : 33'(w_dse);
                        r_ov  <= 1'b0;
                        if (w_cfg_bad) begin
                            r_spd <= '0; r_bad <= 1'b1;
                            r_state <= S_EMIT;
                        end else if (r_sp == r_ep) begin
                            r_ma <= 64'(w_mvs); r_mb <= w_mvm;
                            r_mreq.start <= 1'b1;
                            r_state <= S_ZMUL;
                        end else begin
                            r_ma <= 64'(w_dse[32] ? 33'(-w_dse) : 33'(w_dse));
                            r_mb <= 32'(r_af);
                            r_mreq.start <= 1'b1;
                            r_state <= S_SAC;
                        end
                    end
                end
                S_ZMUL: if (w_mdone) begin
                    r_spd <= w_zsat; r_bad <= 1'b0;
                    r_state <= S_EMIT;
                end
                S_SAC: if (w_mdone) begin
                    r_sac <= w_mp[48:16];
                    r_ma <= 64'(r_ssu); r_mb <= 32'(r_df);
                    r_mreq.start <= 1'b1;
                    r_state <= S_SDE;
                end
                S_SDE: if (w_mdone) begin
                    r_sde <= w_mp[48:16];
                    r_state <= S_CLASS;
                end
                S_CLASS: begin
                    r_bad <= 1'b0;
                    r_ov <= 1'b0;
                    if (r_sac == '0 || r_sde == '0) begin
                        r_spd <= '0; r_bad <= 1'b1;
                        r_state <= S_EMIT;
                    end else if (r_fwd ? (r_ang < w_sp) : (r_ang > w_sp)) begin
                        r_spd <= r_vs; r_ov <= 1'b1; r_state <= S_EMIT;
                    end else if (r_fwd ? (r_ang > w_ep) : (r_ang < w_ep)) begin
                        r_spd <= r_vf; r_ov <= 1'b1; r_state <= S_EMIT;
                    end else if (w_sabs < r_sac) begin
                        r_num <= w_sabs; r_den <= r_sac;
                        r_ma <= 64'(w_mvs); r_mb <= w_mvs;
                        r_mreq.start <= 1'b1;
                        r_state <= S_SQ_A;
                    end else if (w_sabs < w_cruise_end) begin
                        r_spd <= r_vm; r_ov <= 1'b1; r_state <= S_EMIT;
                    end else begin
                        r_num <= r_ssu - w_sabs; r_den <= r_sde;
                        r_ma <= 64'(w_mvf); r_mb <= w_mvf;
                        r_mreq.start <= 1'b1;
                        r_state <= S_SQ_A;
                    end
                end
                S_SQ_A: if (w_mdone) begin
                    r_v2a <= w_mp[63:0];
                    r_ma <= 64'(w_mvm); r_mb <= w_mvm;
                    r_mreq.start <= 1'b1;
                    r_state <= S_SQ_B;
                end
                S_SQ_B: if (w_mdone) begin
                    r_v2b <= w_mp[63:0];
                    if (r_num >= r_den) begin
                        // At the decel start, a full decel phase from the end: pure max speed squared.
                        r_sx <= w_mp[63:0];
                        r_sreq.start <= 1'b1;
                        r_state <= S_ROOT;
                    end else begin
                        r_dn <= {r_num[31:0], 32'd0};
                        r_dd <= r_den;
                        r_dreq.start <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: if (w_ddone) begin
                    r_ma <= (r_v2b >= r_v2a) ? r_v2b - r_v2a : r_v2a - r_v2b;
                    r_mb <= w_dq[31:0];
                    r_mreq.start <= 1'b1;
                    r_state <= S_SCALE;
                end
                S_SCALE: if (w_mdone) begin
                    r_sx <= (r_v2b >= r_v2a) ? r_v2a + w_mp[95:32] : r_v2a - w_mp[95:32];
                    r_sreq.start <= 1'b1;
                    r_state <= S_ROOT;
                end
                S_ROOT: if (w_sdone) begin
                    r_spd <= w_root[31] ? 32'sh7fffffff : $signed(w_root);
                    r_ov <= 1'b1;
                    r_state <= S_EMIT;
                end
                // Write the result once the output register is free.
                S_EMIT: if (!(o_valid && i_stall)) begin
                    if (r_ov) begin
                        if (w_dabs < NEAR) begin
                            r_reached <= 1'b1;
                            r_out_rch <= 1'b1;
                            r_out_spd <= '0;
                        end else begin
                            if (w_dabs > NEAR) begin
                                r_reached <= 1'b0;
                                r_out_rch <= 1'b0;
                            end else begin
                                r_out_rch <= r_reached;
                            end
                            r_out_spd <= f_dir(r_spd, r_fwd);
                        end
                    end else begin
                        r_out_spd <= r_spd;
                        r_out_rch <= r_reached;
                    end
                    r_out_bad <= r_bad;
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_target_speed   = r_out_spd;
    assign o_reached        = r_out_rch;
    assign o_config_invalid = r_out_bad;
endmodule
